// File: hw/rtl/command_frame_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command frame parser
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_PARSER_TOP_MACROS_SVH
`define COMMAND_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication
`define CFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Types, codes and constants shared by the command frame parser modules.
// ----------------------------------------------------------------------------
package cfp_pkg;

	// Default depth of the goal list
	localparam int MAX_GOALS_DEF = 16;

	// Depth of the command queue between parser and reply sequencer
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Header byte layout
	localparam logic [3:0] HDR_NIBBLE = 4'd9;

	// Frame modes
	localparam logic [3:0] MODE_NONE    = 4'd0;
	localparam logic [3:0] MODE_CMD1    = 4'd1;
	localparam logic [3:0] MODE_VEL     = 4'd4;
	localparam logic [3:0] MODE_POS     = 4'd5;
	localparam logic [3:0] MODE_STN     = 4'd6;
	localparam logic [3:0] MODE_GOALS   = 4'd7;
	localparam logic [3:0] MODE_RPT_STN = 4'd9;
	localparam logic [3:0] MODE_RPT_POS = 4'd10;
	localparam logic [3:0] MODE_RPT_SPD = 4'd11;
	localparam logic [3:0] MODE_LAST    = 4'd14;

	// Acknowledge bytes "Xu"
	localparam logic [7:0] ACK_X = 8'd88;
	localparam logic [7:0] ACK_U = 8'd117;

	// Reply frame headers
	localparam logic [7:0] RPT_HDR_STN = 8'd153;
	localparam logic [7:0] RPT_HDR_POS = 8'd154;
	localparam logic [7:0] RPT_HDR_SPD = 8'd155;

	// Reply byte slots
	localparam logic [2:0] SLOT_ACK_X   = 3'd0;
	localparam logic [2:0] SLOT_ACK_U   = 3'd1;
	localparam logic [2:0] SLOT_RPT_HDR = 3'd2;
	localparam logic [2:0] SLOT_RPT_HI  = 3'd3;
	localparam logic [2:0] SLOT_RPT_LO  = 3'd4;
	localparam logic [2:0] SLOT_RPT_CHK = 3'd5;

	// Configuration register indexes
	localparam logic CFG_STATION = 1'b0;
	localparam logic CFG_MAX_VEL = 1'b1;

	// Parser phases
	typedef enum logic [2:0] {
		PH_HUNT,
		PH_DATA1,
		PH_DATA2,
		PH_COUNT,
		PH_GOALS,
		PH_CHECK
	} phase_t;

	// One checked frame, ready to execute
	typedef struct packed {
		logic [3:0]  mode;
		logic [7:0]  data1;
		logic [7:0]  data2;
		logic [4:0]  count;
		logic [15:0] pos;
	} cmd_t;

	// Parser to queue
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	// Queue head to sequencer
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

// File: hw/rtl/cfp_front.sv
// ----------------------------------------------------------------------------
// cfp_front
// Frame parser: hunts for headers, sums the frame and pushes checked frames.
// ----------------------------------------------------------------------------
module cfp_front #(
	parameter int MAX_GOALS = cfp_pkg::MAX_GOALS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     rx_byte,
	input  logic [15:0]    current_position_code,
	output cfp_pkg::q_wr_t wr
);

	localparam int CNT_W = $clog2(MAX_GOALS + 1);
	localparam logic [7:0] MAX_CNT = 8'(MAX_GOALS);

	cfp_pkg::phase_t phase_q, phase_d;
	logic [7:0]       header_q, header_d;
	logic [7:0]       data1_q, data1_d;
	logic [7:0]       data2_q, data2_d;
	logic [7:0]       sum_q, sum_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	logic [4:0]       count_q, count_d;
	logic [3:0]       rx_mode;
	logic             is_header;

	assign rx_mode   = rx_byte[3:0];
	assign is_header = (rx_byte[7:4] == cfp_pkg::HDR_NIBBLE) &&
		(rx_mode != cfp_pkg::MODE_NONE) && (rx_mode <= cfp_pkg::MODE_LAST);

	// Hold phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfp_pkg::PH_HUNT;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Hold frame fields
	always_ff @(posedge clk) begin
		header_q <= header_d;
		data1_q  <= data1_d;
		data2_q  <= data2_d;
		sum_q    <= sum_d;
		rem_q    <= rem_d;
		count_q  <= count_d;
	end

	// Advance the parser on each accepted byte
	always_comb begin
		phase_d      = phase_q;
		header_d     = header_q;
		data1_d      = data1_q;
		data2_d      = data2_q;
		sum_d        = sum_q;
		rem_d        = rem_q;
		count_d      = count_q;
		wr.push      = 1'b0;
		wr.cmd.mode  = header_q[3:0];
		wr.cmd.data1 = data1_q;
		wr.cmd.data2 = data2_q;
		wr.cmd.count = count_q;
		wr.cmd.pos   = current_position_code;
		if (take) begin
			unique case (phase_q)
				cfp_pkg::PH_HUNT: begin
					if (is_header) begin
						header_d = rx_byte;
						sum_d    = rx_byte;
						unique case (rx_mode) inside
							cfp_pkg::MODE_CMD1, [cfp_pkg::MODE_VEL:cfp_pkg::MODE_STN]:
								phase_d = cfp_pkg::PH_DATA1;
							cfp_pkg::MODE_GOALS:
								phase_d = cfp_pkg::PH_COUNT;
							default:
								phase_d = cfp_pkg::PH_CHECK;
						endcase
					end
				end
				cfp_pkg::PH_DATA1: begin
					data1_d = rx_byte;
					sum_d   = sum_q + rx_byte;
					phase_d = cfp_pkg::PH_DATA2;
				end
				cfp_pkg::PH_DATA2: begin
					data2_d = rx_byte;
					sum_d   = sum_q + rx_byte;
					phase_d = cfp_pkg::PH_CHECK;
				end
				cfp_pkg::PH_COUNT: begin
					// Drop the frame when the count exceeds the goal list
					if (rx_byte > MAX_CNT) begin
						phase_d = cfp_pkg::PH_HUNT;
					end else begin
						count_d = rx_byte[4:0];
						rem_d   = rx_byte[CNT_W-1:0];
						sum_d   = sum_q + rx_byte;
						phase_d = (rx_byte == 8'd0) ? cfp_pkg::PH_CHECK : cfp_pkg::PH_GOALS;
					end
				end
				cfp_pkg::PH_GOALS: begin
					sum_d = sum_q + rx_byte;
					rem_d = rem_q - CNT_W'(1);
					if (rem_q == CNT_W'(1)) begin
						phase_d = cfp_pkg::PH_CHECK;
					end
				end
				cfp_pkg::PH_CHECK: begin
					wr.push = (rx_byte == ~sum_q);
					phase_d = cfp_pkg::PH_HUNT;
				end
				default: begin
					phase_d = cfp_pkg::PH_HUNT;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/cfp_queue.sv
// ----------------------------------------------------------------------------
// cfp_queue
// Short command queue between the frame parser and the reply sequencer.
// ----------------------------------------------------------------------------
module cfp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  cfp_pkg::q_wr_t   wr,
	input  logic             pop,
	output cfp_pkg::q_head_t head,
	output logic             full
);

	localparam int PW = cfp_pkg::QUEUE_PTR_W;

	cfp_pkg::cmd_t entry_q [cfp_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   fill_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (fill_q == (PW+1)'(cfp_pkg::QUEUE_DEPTH));
	assign head.valid = (fill_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];
	assign do_push   = wr.push && !full;
	assign do_pop    = pop && head.valid;

	// Store pushed transaction
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr.cmd;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (PW+1)'(1);
			end
		end
	end

endmodule

// File: hw/rtl/cfp_back.sv
// ----------------------------------------------------------------------------
// cfp_back
// Reply sequencer: applies each checked frame and sends its reply bytes.
// ----------------------------------------------------------------------------
`include "command_frame_parser_top_macros.svh"

module cfp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cfp_pkg::q_head_t head,
	output logic             pop,
	input  logic [7:0]       station_number,
	input  logic [7:0]       max_velocity_code,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       tx_byte,
	output logic             last_of_run,
	output logic [3:0]       active_mode,
	output logic [7:0]       velocity_setting,
	output logic [15:0]      position_setting,
	output logic [7:0]       goal_station,
	output logic [4:0]       goal_count
);

	logic [2:0]  slot_q;
	logic        out_valid_q;
	logic [7:0]  vel_q, vel_d;
	logic [15:0] pos_q, pos_d;
	logic [7:0]  stn_q, stn_d;
	logic [4:0]  cnt_q, cnt_d;
	logic        load;
	logic        is_reply;
	logic [2:0]  last_slot;
	logic        last_d;
	logic [7:0]  rpt_hdr, rpt_hi, rpt_lo, rpt_chk;
	logic [7:0]  byte_d;
	logic [7:0]  tx_byte_q;
	logic        last_q;
	logic [3:0]  mode_out_q;
	logic [7:0]  vel_out_q;
	logic [15:0] pos_out_q;
	logic [7:0]  stn_out_q;
	logic [4:0]  cnt_out_q;

	// Load a byte whenever a frame is at the queue head and the output register is free or being taken
	assign load      = head.valid && (!out_valid_q || !out_stall);
	assign is_reply  = (head.cmd.mode == cfp_pkg::MODE_RPT_STN) ||
		(head.cmd.mode == cfp_pkg::MODE_RPT_POS) || (head.cmd.mode == cfp_pkg::MODE_RPT_SPD);
	assign last_slot = is_reply ? cfp_pkg::SLOT_RPT_CHK : cfp_pkg::SLOT_ACK_U;
	assign last_d    = (slot_q == last_slot);
	assign pop       = load && last_d;

	// Settings after this frame's update
	always_comb begin
		vel_d = (head.cmd.mode == cfp_pkg::MODE_VEL) ? head.cmd.data2 : vel_q;
		pos_d = (head.cmd.mode == cfp_pkg::MODE_POS) ? {head.cmd.data1, head.cmd.data2} : pos_q;
		stn_d = (head.cmd.mode == cfp_pkg::MODE_STN) ? head.cmd.data2 : stn_q;
		cnt_d = (head.cmd.mode == cfp_pkg::MODE_GOALS) ? head.cmd.count : cnt_q;
	end

	// Build the reply frame
	always_comb begin
		rpt_hdr = cfp_pkg::RPT_HDR_SPD;
		rpt_hi  = 8'd0;
		rpt_lo  = max_velocity_code;
		if (head.cmd.mode == cfp_pkg::MODE_RPT_STN) begin
			rpt_hdr = cfp_pkg::RPT_HDR_STN;
			rpt_lo  = station_number;
		end else if (head.cmd.mode == cfp_pkg::MODE_RPT_POS) begin
			rpt_hdr = cfp_pkg::RPT_HDR_POS;
			rpt_hi  = head.cmd.pos[15:8];
			rpt_lo  = head.cmd.pos[7:0];
		end
		rpt_chk = ~(rpt_hdr + rpt_hi + rpt_lo);
	end

	// Pick the byte for this slot
	always_comb begin
		unique case (slot_q)
			cfp_pkg::SLOT_ACK_X:   byte_d = cfp_pkg::ACK_X;
			cfp_pkg::SLOT_ACK_U:   byte_d = cfp_pkg::ACK_U;
			cfp_pkg::SLOT_RPT_HDR: byte_d = rpt_hdr;
			cfp_pkg::SLOT_RPT_HI:  byte_d = rpt_hi;
			cfp_pkg::SLOT_RPT_LO:  byte_d = rpt_lo;
			cfp_pkg::SLOT_RPT_CHK: byte_d = rpt_chk;
			default:               byte_d = 8'd0;
		endcase
	end

	// Step through slots and update settings on the first byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= cfp_pkg::SLOT_ACK_X;
			out_valid_q <= 1'b0;
			vel_q       <= '0;
			pos_q       <= '0;
			stn_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= head.valid;
			end
			if (load) begin
				slot_q <= last_d ? cfp_pkg::SLOT_ACK_X : slot_q + 3'd1;
				vel_q  <= vel_d;
				pos_q  <= pos_d;
				stn_q  <= stn_d;
				cnt_q  <= cnt_d;
			end
		end
	end

	// Hold the output transaction
	always_ff @(posedge clk) begin
		if (load) begin
			tx_byte_q  <= byte_d;
			last_q     <= last_d;
			mode_out_q <= head.cmd.mode;
			vel_out_q  <= vel_d;
			pos_out_q  <= pos_d;
			stn_out_q  <= stn_d;
			cnt_out_q  <= cnt_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign tx_byte          = tx_byte_q;
	assign last_of_run      = last_q;
	assign active_mode      = mode_out_q;
	assign velocity_setting = vel_out_q;
	assign position_setting = pos_out_q;
	assign goal_station     = stn_out_q;
	assign goal_count       = cnt_out_q;

	// A plain acknowledge ends after its second byte
	`CFP_ASSERT_NOW(a_ack_end, load && last_d && (slot_q == cfp_pkg::SLOT_ACK_U), !is_reply, "ack run ended on a reply mode")
	// The end of a run restarts at the first slot
	`CFP_ASSERT_NEXT(a_run_wrap, load && last_d, slot_q == cfp_pkg::SLOT_ACK_X, "slot did not wrap after last byte")
	// The slot never runs past the reply checksum
	`CFP_ASSERT_NOW(a_slot_range, 1'b1, slot_q <= cfp_pkg::SLOT_RPT_CHK, "slot beyond reply frame")

endmodule

// File: hw/rtl/command_frame_parser_top.sv
// ----------------------------------------------------------------------------
// command_frame_parser_top
// Byte-serial command frame parser with acknowledge and reply generation.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+---------------------------------
//  in        | in_valid / in_stall          | rx_byte, current_position_code
//  out       | out_valid / out_stall        | tx_byte, last_of_run, settings
//  config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
//  The parser takes one byte per cycle unless stalled; in_stall rises only
//  while the four-entry command queue is full.
//  Each checked frame gives 2 reply bytes, or 6 for modes 9 to 11, one per
//  cycle from the reply sequencer unless stalled; its output register paces it.
//  Out transactions are registered from the frame at the queue head.
//  Reset clears parser phase, queue, sequencer and the setting registers;
//  configuration returns to station 5 and speed code 229.
//
module command_frame_parser_top #(
	parameter int MAX_GOALS = cfp_pkg::MAX_GOALS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// received bytes
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] current_position_code,
	// transmitted bytes
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        last_of_run,
	output logic [3:0]  active_mode,
	output logic [7:0]  velocity_setting,
	output logic [15:0] position_setting,
	output logic [7:0]  goal_station,
	output logic [4:0]  goal_count
);

	logic             cfg_idx;
	logic [7:0]       station_number_q;
	logic [7:0]       max_velocity_code_q;
	logic             cfg_wr;
	logic             queue_full;
	logic             take;
	logic             pop;
	cfp_pkg::q_wr_t   wr;
	cfp_pkg::q_head_t head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[2];

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_number_q    <= 8'd5;
			max_velocity_code_q <= 8'd229;
		end else if (cfg_wr) begin
			case (cfg_idx)
				cfp_pkg::CFG_STATION: station_number_q    <= pwdata[7:0];
				cfp_pkg::CFG_MAX_VEL: max_velocity_code_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back configuration
	always_comb begin
		case (cfg_idx)
			cfp_pkg::CFG_STATION: prdata = {24'd0, station_number_q};
			cfp_pkg::CFG_MAX_VEL: prdata = {24'd0, max_velocity_code_q};
			default:              prdata = 32'd0;
		endcase
	end

	// Stall input while the queue is full
	assign in_stall = queue_full;
	assign take     = in_valid && !in_stall;

	cfp_front #(
		.MAX_GOALS(MAX_GOALS)
	) u_front (
		.clk                   (clk),
		.arst_n                (arst_n),
		.take                  (take),
		.rx_byte               (rx_byte),
		.current_position_code (current_position_code),
		.wr                    (wr)
	);

	cfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.head   (head),
		.full   (queue_full)
	);

	cfp_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head              (head),
		.pop               (pop),
		.station_number    (station_number_q),
		.max_velocity_code (max_velocity_code_q),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.tx_byte           (tx_byte),
		.last_of_run       (last_of_run),
		.active_mode       (active_mode),
		.velocity_setting  (velocity_setting),
		.position_setting  (position_setting),
		.goal_station      (goal_station),
		.goal_count        (goal_count)
	);

endmodule
